// ===== sv/stereo_delay_line_with_gain_core_assert.svh =====
// Assertion macros for the stereo delay line core.
// Expects clk and rst in the including module's scope.
`ifndef STEREO_DELAY_LINE_WITH_GAIN_CORE_ASSERT_SVH
`define STEREO_DELAY_LINE_WITH_GAIN_CORE_ASSERT_SVH

// same-cycle implication
`define SDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sdl_pkg.sv =====
// Shared types and constants for the stereo delay line core.
// No dependencies.
package sdl_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int STORE_DEPTH_DFLT = 131072;
  localparam int DELAY_W          = 18;
  localparam int GAIN_W           = 16;
  localparam int FRAC_BITS        = 14;
  localparam int PROD_W           = SAMPLE_BITS + GAIN_W + 1;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);

  localparam logic [1:0] REG_DELAY_LEFT  = 2'd0;
  localparam logic [1:0] REG_DELAY_RIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN_LEFT   = 2'd2;
  localparam logic [1:0] REG_GAIN_RIGHT  = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_pair_t;

  typedef struct packed {
    logic restart;
    logic accept;
    logic load2;
  } lane_ctl_t;

endpackage

// ===== sv/sdl_lane.sv =====
// One channel lane: ring store, fill tracking and gain multiply.
// Depends on sdl_pkg.
module sdl_lane #(
  parameter int STORE_DEPTH = sdl_pkg::STORE_DEPTH_DFLT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sdl_pkg::lane_ctl_t                      ctl,
  input  logic signed [sdl_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic [sdl_pkg::DELAY_W-1:0]             delay,
  input  logic [sdl_pkg::GAIN_W-1:0]              gain,
  output logic signed [sdl_pkg::PROD_W-1:0]       prod
);
  import sdl_pkg::*;

  localparam int PW = $clog2(STORE_DEPTH + 1);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = (PW > DELAY_W) ? PW : DELAY_W;

  logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

  logic [PW-1:0] pos;
  logic          primed;
  logic [PW-1:0] d_eff;
  logic [PW-1:0] pos_sel;
  logic [PW-1:0] pos_inc;
  logic          wrap;
  logic          mem_en;

  logic signed [SAMPLE_BITS-1:0] rd;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          bypass_q;
  logic                          primed_q;
  logic signed [SAMPLE_BITS-1:0] sel;

  always_comb begin
    if (CW'(delay) > CW'(STORE_DEPTH)) begin
      d_eff = PW'(STORE_DEPTH);
    end else begin
      d_eff = PW'(delay);
    end
    pos_sel = (pos >= d_eff) ? '0 : pos;
    pos_inc = pos_sel + PW'(1);
    wrap    = (pos_inc >= d_eff);
    mem_en  = ctl.accept && (d_eff != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      primed <= 1'b0;
    end else if (ctl.restart) begin
      pos    <= '0;
      primed <= 1'b0;
    end else if (mem_en) begin
      if (wrap) begin
        pos    <= '0;
        primed <= 1'b1;
      end else begin
        pos <= pos_inc;
      end
    end
  end

  // read-first ring store
  always_ff @(posedge clk) begin
    if (mem_en) begin
      rd                   <= mem[pos_sel[AW-1:0]];
      mem[pos_sel[AW-1:0]] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_q      <= sample;
      bypass_q <= (d_eff == '0);
      primed_q <= primed;
    end
  end

  always_comb begin
    if (bypass_q) begin
      sel = x_q;
    end else if (primed_q) begin
      sel = rd;
    end else begin
      sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load2) begin
      prod <= PROD_W'(sel) * PROD_W'($signed({1'b0, gain}));
    end
  end

  `include "stereo_delay_line_with_gain_core_assert.svh"

  `SDL_ASSERT_NEXT(a_restart_clears, ctl.restart, (pos == '0) && !primed, "fill not restarted")
  `SDL_ASSERT_NOW(a_pos_in_ring, d_eff != '0, pos < d_eff, "ring position past delay")
  `SDL_ASSERT_NEXT(a_zero_delay_bypass, ctl.accept && (d_eff == '0), bypass_q, "bypass not taken")

endmodule

// ===== sv/sdl_merge.sv =====
// Merge stage: rounds and saturates both lane products into the output register.
// Depends on sdl_pkg.
module sdl_merge (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [sdl_pkg::PROD_W-1:0] prod_left,
  input  logic signed [sdl_pkg::PROD_W-1:0] prod_right,
  output sdl_pkg::out_pair_t                data
);
  import sdl_pkg::*;

  localparam int QW = PROD_W + 1;
  localparam logic signed [QW-1:0] HALF = QW'(1 << (FRAC_BITS - 1));
  localparam logic signed [QW-1:0] HI   = QW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] LO   = -HI - QW'(1);

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] r;
    q = QW'(p) + HALF;
    r = q >>> FRAC_BITS;
    if (r > HI) begin
      return HI[SAMPLE_BITS-1:0];
    end else if (r < LO) begin
      return LO[SAMPLE_BITS-1:0];
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      data.left_out  <= round_sat(prod_left);
      data.right_out <= round_sat(prod_right);
    end
  end

endmodule

// ===== sv/stereo_delay_line_with_gain_core.sv =====
// Stereo delay line with per-channel gain: top level, register file, flow control.
// Depends on sdl_pkg, sdl_lane, sdl_merge.
//
// Usage: one stereo pair per input beat (in_valid/in_stall, payload in_data),
// one scaled pair per output beat (out_valid/out_stall, payload out_data).
// Each channel delays by its delay register (clamped to STORE_DEPTH) and
// scales by its Q2.14 gain with round-half-up and 24-bit saturation. After
// reset or any register write both channels output zero for their first D
// beats while the ring store fills; a zero delay passes the input straight
// through the gain.
// An accepted pair passes the lane sample/read registers, the product register and
// the output register. Throughput: one pair per cycle while out_stall is low;
// each lane makes one read-first access to its single-port ring store per beat.
// Stall: the three stages hold and fill bubbles independently, so input is
// taken until all of them are full behind a stalled output.
// Reset (rst, synchronous): delays 0, gains unity, empty pipeline; no clearing
// pass, the store is only used where written this fill. Registers are written
// through the APB-style port; the user must do so only while idle (not enforced).
module stereo_delay_line_with_gain_core #(
  parameter int STORE_DEPTH = sdl_pkg::STORE_DEPTH_DFLT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sdl_pkg::in_pair_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sdl_pkg::out_pair_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sdl_pkg::ADDR_W-1:0]   paddr,
  input  logic [sdl_pkg::DATA_W-1:0]   pwdata,
  output logic [sdl_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import sdl_pkg::*;

  logic [DELAY_W-1:0] delay_left;
  logic [DELAY_W-1:0] delay_right;
  logic [GAIN_W-1:0]  gain_left;
  logic [GAIN_W-1:0]  gain_right;

  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic accept;
  lane_ctl_t ctl;

  logic signed [PROD_W-1:0] prod_left;
  logic signed [PROD_W-1:0] prod_right;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_left  <= '0;
      delay_right <= '0;
      gain_left   <= GAIN_UNITY;
      gain_right  <= GAIN_UNITY;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DELAY_LEFT:  delay_left  <= pwdata[DELAY_W-1:0];
        REG_DELAY_RIGHT: delay_right <= pwdata[DELAY_W-1:0];
        REG_GAIN_LEFT:   gain_left   <= pwdata[GAIN_W-1:0];
        REG_GAIN_RIGHT:  gain_right  <= pwdata[GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DELAY_LEFT:  prdata = DATA_W'(delay_left);
      REG_DELAY_RIGHT: prdata = DATA_W'(delay_right);
      REG_GAIN_LEFT:   prdata = DATA_W'(gain_left);
      REG_GAIN_RIGHT:  prdata = DATA_W'(gain_right);
    endcase
  end

  // per-stage advance, bubbles collapse
  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;

  always_comb begin
    ctl.restart = cfg_wr;
    ctl.accept  = accept;
    ctl.load2   = en2 && v1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  sdl_lane #(.STORE_DEPTH(STORE_DEPTH)) u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (in_data.left_sample),
    .delay  (delay_left),
    .gain   (gain_left),
    .prod   (prod_left)
  );

  sdl_lane #(.STORE_DEPTH(STORE_DEPTH)) u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (in_data.right_sample),
    .delay  (delay_right),
    .gain   (gain_right),
    .prod   (prod_right)
  );

  sdl_merge u_merge (
    .clk        (clk),
    .load       (en3 && v2),
    .prod_left  (prod_left),
    .prod_right (prod_right),
    .data       (out_data)
  );

  assign out_valid = v3;

  `include "stereo_delay_line_with_gain_core_assert.svh"

  `SDL_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v1, "accepted beat lost")
  `SDL_ASSERT_NOW(a_full_stalls, v1 && v2 && v3 && out_stall, in_stall, "overrun of full pipe")
  `SDL_ASSERT_NEXT(a_drain, v2 && !(v3 && out_stall), v3, "stage two beat dropped")

endmodule
